### src/kfpv_pkg.sv
// kfpv_pkg: shared constants, types and saturation helpers for the
// constant-velocity Kalman filter. No dependencies.
`default_nettype none
package kfpv_pkg;

	// Time step, Q0.32, and its powers (truncated products)
	localparam logic [63:0] DT_FRACTION = 64'd4294967;
	localparam logic [63:0] DT  = DT_FRACTION & 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] DT2 = (DT * DT) >> 32;
	localparam logic [63:0] DT3 = (DT2 * DT) >> 32;
	localparam logic [63:0] DT4 = (DT3 * DT) >> 32;

	// Magnitude ceiling of every product and quotient
	localparam logic [63:0] MAG_CAP = 64'h4000_0000_0000_0000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEAS_NOISE,
		REG_PROC_NOISE,
		REG_INIT_POS,
		REG_INIT_VEL,
		REG_INIT_COV_PP,
		REG_INIT_COV_PV,
		REG_INIT_COV_VP,
		REG_INIT_COV_VV
	} kfpv_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_CALC,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} kfpv_state_t;

	// Product sequence: prediction terms, then the correction terms
	typedef enum logic [3:0] {
		OP_Q4,
		OP_Q3,
		OP_Q2,
		OP_P22DT,
		OP_P21DT,
		OP_APRED,
		OP_VDT,
		OP_K1Y,
		OP_K2Y,
		OP_K1A,
		OP_K1C,
		OP_K2A,
		OP_K2C
	} kfpv_op_t;

	function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
		if (v > 66'sd140737488355327)
			return 48'sh7FFF_FFFF_FFFF;
		else if (v < -66'sd140737488355328)
			return 48'sh8000_0000_0000;
		else
			return v[47:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -66'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage
`default_nettype wire

### src/kfpv_meas_if.sv
// kfpv_meas_if: input channel, measured position or reload request.
// Standalone, no dependencies.
`default_nettype none
interface kfpv_meas_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measured_position;
	logic               reload;

	modport source(output valid, measured_position, reload, input ready);
	modport sink(input valid, measured_position, reload, output ready);
endinterface
`default_nettype wire

### src/kfpv_result_if.sv
// kfpv_result_if: output channel, filtered estimate and fault flag.
// Standalone, no dependencies.
`default_nettype none
interface kfpv_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] est_position;
	logic signed [31:0] est_velocity;
	logic signed [47:0] position_variance;
	logic               fault;

	modport source(output valid, est_position, est_velocity, position_variance, fault,
		input ready);
	modport sink(input valid, est_position, est_velocity, position_variance, fault,
		output ready);
endinterface
`default_nettype wire

### src/kfpv_mul.sv
// kfpv_mul: shared fixed-point multiplier, (a*b)>>32 toward zero, capped.
// One 32x32 partial product per cycle. Uses kfpv_pkg.
`default_nettype none
module kfpv_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output logic                    done,
	output logic signed [63:0]      prod
);
	import kfpv_pkg::*;

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, fin_q, done_q;
	logic signed [63:0] prod_q;

	logic [31:0]  xa, xb;
	logic [6:0]   sh;
	logic [63:0]  pp;
	logic [127:0] term;
	logic [63:0]  r, rm;
	logic         over;

	always_comb begin
		case (cnt_q)
			2'd0: begin xa = ua_q[31:0];  xb = ub_q[31:0];  sh = 7'd0;  end
			2'd1: begin xa = ua_q[31:0];  xb = ub_q[63:32]; sh = 7'd32; end
			2'd2: begin xa = ua_q[63:32]; xb = ub_q[31:0];  sh = 7'd32; end
			default: begin xa = ua_q[63:32]; xb = ub_q[63:32]; sh = 7'd64; end
		endcase
		pp   = {32'b0, xa} * {32'b0, xb};
		term = {64'b0, pp} << sh;
		r    = acc_q[95:32];
		over = (|acc_q[127:96]) || (r > MAG_CAP);
		rm   = over ? MAG_CAP : r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			fin_q  <= busy_q && !start && (cnt_q == 2'd3);
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[63] ? 64'(-a) : 64'(a);
			ub_q  <= b[63] ? 64'(-b) : 64'(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + term;
		end
		if (fin_q)
			prod_q <= neg_q ? -$signed(rm) : $signed(rm);
	end

	assign done = done_q;
	assign prod = prod_q;
endmodule
`default_nettype wire

### src/kfpv_div.sv
// kfpv_div: restoring divider, (n<<32)/d for d>0, one quotient bit a cycle.
// Quotient capped, then saturated to 48 bits. Uses kfpv_pkg.
`default_nettype none
module kfpv_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [47:0] n,
	input  wire logic [48:0]        d,
	output logic                    done,
	output logic signed [47:0]      quo
);
	import kfpv_pkg::*;

	logic [95:0] num_q;
	logic [48:0] ud_q;
	logic [49:0] rem_q;
	logic [63:0] q_q;
	logic        ovf_q, neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q, fin_q, done_q;
	logic signed [47:0] quo_q;

	logic [49:0] rem2, rem_n;
	logic [63:0] q_sh, q_n, qf;
	logic        ovf_n, ge;
	logic [47:0] mag;

	always_comb begin
		mag   = n[47] ? 48'(-n) : 48'(n);
		rem2  = {rem_q[48:0], num_q[95]};
		ovf_n = ovf_q || (q_q >= MAG_CAP);
		q_sh  = (q_q >= MAG_CAP) ? q_q : {q_q[62:0], 1'b0};
		ge    = rem2 >= {1'b0, ud_q};
		rem_n = ge ? rem2 - {1'b0, ud_q} : rem2;
		q_n   = (ge && !ovf_n) ? (q_sh | 64'd1) : q_sh;
		qf    = ovf_q ? MAG_CAP : q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			fin_q  <= busy_q && !start && (cnt_q == 7'd95);
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd95)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {16'b0, mag, 32'b0};
			ud_q  <= d;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			neg_q <= n[47];
		end else if (busy_q) begin
			num_q <= {num_q[94:0], 1'b0};
			rem_q <= rem_n;
			q_q   <= q_n;
			ovf_q <= ovf_n;
		end
		if (fin_q)
			quo_q <= sat48(neg_q ? -66'(qf) : 66'(qf));
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### src/kalman_filter_position_velocity_unit.sv
// Two-state constant-velocity Kalman filter, sequenced over one shared
// multiplier (built from 32x32 partial products) and one bit-serial divider.
// A reload loads the initial state and goes to the result. A filter step takes 7
// prediction products; for positive innovation variance, 2 gains, 6 corrections.
// One transaction at a time; the output register frees the input side.
// Reset (arst_n low): state, configuration and covariance cleared, output invalid.
`default_nettype none
module kalman_filter_position_velocity_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	kfpv_meas_if.sink                                meas,
	kfpv_result_if.source                            result,
	input  wire logic                                cfg_we,
	input  wire logic [kfpv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kfpv_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import kfpv_pkg::*;

	// Configuration registers
	logic [46:0]        rr_q, qq_q;
	logic signed [31:0] ip_q, iv_q;
	logic signed [47:0] ic_q [4];

	// Filter state
	logic signed [31:0] pos_q, vel_q;
	logic signed [47:0] cov_q [4];

	// Sequencer
	kfpv_state_t state_q, state_n;
	kfpv_op_t    op_q;
	logic        div_sel_q;

	// Intermediate terms
	logic signed [31:0] meas_q, xp_q;
	logic signed [63:0] q4_q, q3_q, q2_q, p22dt_q, t1_q, t2_q, vdt_q;
	logic signed [47:0] a_q, b_q, c_q, d_q, k1_q, k2_q;
	logic signed [48:0] s_q;
	logic signed [32:0] y_q;
	logic               fault_q;

	// Output register
	logic               out_valid_q;
	logic signed [31:0] out_pos_q, out_vel_q;
	logic signed [47:0] out_var_q;
	logic               out_fault_q;

	// Shared units
	logic               mul_start, mul_done;
	logic signed [63:0] mul_a, mul_b, mul_p;
	logic               div_start, div_done;
	logic signed [47:0] div_n, div_q;

	logic               accept, out_free;

	// Prediction, formed in one step once all products are in
	logic signed [47:0] a_n, b_n, c_n, d_n;
	logic signed [31:0] xp_n;
	logic signed [48:0] s_n;

	assign accept   = meas.valid && meas.ready;
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		a_n  = sat48(66'(cov_q[0]) + 66'(t1_q) + 66'(q4_q) + 66'(t2_q));
		b_n  = sat48(66'(q3_q) + 66'(p22dt_q) + 66'(cov_q[2]));
		c_n  = sat48(66'(q3_q) + 66'(p22dt_q) + 66'(cov_q[1]));
		d_n  = sat48(66'(cov_q[3]) + 66'(q2_q));
		xp_n = sat32(66'(pos_q) + 66'(vdt_q));
		s_n  = 49'(a_n) + $signed({2'b00, rr_q});
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:     if (meas.valid) state_n = meas.reload ? ST_OUT : ST_MUL_GO;
			ST_MUL_GO:   state_n = ST_MUL_WAIT;
			ST_MUL_WAIT: if (mul_done) begin
				if (op_q == OP_VDT)
					state_n = ST_CALC;
				else if (op_q == OP_K2C)
					state_n = ST_OUT;
				else
					state_n = ST_MUL_GO;
			end
			ST_CALC:     state_n = (s_n[48] || s_n == '0) ? ST_OUT : ST_DIV_GO;
			ST_DIV_GO:   state_n = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_n = div_sel_q ? ST_MUL_GO : ST_DIV_GO;
			ST_OUT:      if (out_free) state_n = ST_IDLE;
			default:     state_n = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		meas.ready = 1'b0;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		unique case (state_q)
			ST_IDLE:   meas.ready = 1'b1;
			ST_MUL_GO: mul_start  = 1'b1;
			ST_DIV_GO: div_start  = 1'b1;
			default: ;
		endcase
	end

	// Operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_Q4:    begin mul_a = 64'({17'b0, qq_q}); mul_b = DT4; end
			OP_Q3:    begin mul_a = 64'({17'b0, qq_q}); mul_b = DT3; end
			OP_Q2:    begin mul_a = 64'({17'b0, qq_q}); mul_b = DT2; end
			OP_P22DT: begin mul_a = 64'(cov_q[3]); mul_b = DT; end
			OP_P21DT: begin mul_a = 64'(cov_q[2]); mul_b = DT; end
			OP_APRED: begin mul_a = DT; mul_b = 64'(cov_q[1]) + p22dt_q; end
			OP_VDT:   begin mul_a = 64'(vel_q); mul_b = DT; end
			OP_K1Y:   begin mul_a = 64'(k1_q); mul_b = 64'(y_q); end
			OP_K2Y:   begin mul_a = 64'(k2_q); mul_b = 64'(y_q); end
			OP_K1A:   begin mul_a = 64'(k1_q); mul_b = 64'(a_q); end
			OP_K1C:   begin mul_a = 64'(k1_q); mul_b = 64'(c_q); end
			OP_K2A:   begin mul_a = 64'(k2_q); mul_b = 64'(a_q); end
			OP_K2C:   begin mul_a = 64'(k2_q); mul_b = 64'(c_q); end
			default: ;
		endcase
	end

	assign div_n = div_sel_q ? b_q : a_q;

	kfpv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	kfpv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (s_q[48:0]),
		.done   (div_done),
		.quo    (div_q)
	);

	// Control, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_Q4;
			div_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
			rr_q        <= '0;
			qq_q        <= '0;
			ip_q        <= '0;
			iv_q        <= '0;
			pos_q       <= '0;
			vel_q       <= '0;
			for (int i = 0; i < 4; i++) begin
				ic_q[i]  <= '0;
				cov_q[i] <= '0;
			end
		end else begin
			state_q <= state_n;

			if (cfg_we) begin
				unique case (kfpv_reg_t'(cfg_index))
					REG_MEAS_NOISE:  rr_q    <= cfg_data[46:0];
					REG_PROC_NOISE:  qq_q    <= cfg_data[46:0];
					REG_INIT_POS:    ip_q    <= cfg_data[31:0];
					REG_INIT_VEL:    iv_q    <= cfg_data[31:0];
					REG_INIT_COV_PP: ic_q[0] <= cfg_data;
					REG_INIT_COV_PV: ic_q[1] <= cfg_data;
					REG_INIT_COV_VP: ic_q[2] <= cfg_data;
					REG_INIT_COV_VV: ic_q[3] <= cfg_data;
					default: ;
				endcase
			end

			// Result register: a new result waits until the previous one is taken
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			if (state_q == ST_IDLE && accept) begin
				op_q <= OP_Q4;
				if (meas.reload) begin
					pos_q <= ip_q;
					vel_q <= iv_q;
					for (int i = 0; i < 4; i++)
						cov_q[i] <= ic_q[i];
				end
			end

			if (state_q == ST_MUL_WAIT && mul_done) begin
				op_q <= kfpv_op_t'(op_q + 4'd1);
				case (op_q)
					OP_K1Y: pos_q    <= sat32(66'(xp_q) + 66'(mul_p));
					OP_K2Y: vel_q    <= sat32(66'(vel_q) + 66'(mul_p));
					OP_K1A: cov_q[0] <= sat48(66'(a_q) - 66'(mul_p));
					OP_K1C: cov_q[1] <= sat48(66'(c_q) - 66'(mul_p));
					OP_K2A: cov_q[2] <= sat48(66'(b_q) - 66'(mul_p));
					OP_K2C: cov_q[3] <= sat48(66'(d_q) - 66'(mul_p));
					default: ;
				endcase
			end

			if (state_q == ST_CALC) begin
				div_sel_q <= 1'b0;
				// Nonpositive innovation variance: keep the prediction only
				if (s_n[48] || s_n == '0) begin
					pos_q    <= xp_n;
					cov_q[0] <= a_n;
					cov_q[1] <= c_n;
					cov_q[2] <= b_n;
					cov_q[3] <= d_n;
				end
			end

			if (state_q == ST_DIV_WAIT && div_done) begin
				div_sel_q <= 1'b1;
				if (div_sel_q)
					op_q <= OP_K1Y;
			end
		end
	end

	// Working registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			meas_q  <= meas.measured_position;
			fault_q <= 1'b0;
		end

		if (state_q == ST_MUL_WAIT && mul_done) begin
			case (op_q)
				OP_Q4:    q4_q    <= mul_p >>> 2;
				OP_Q3:    q3_q    <= mul_p >>> 1;
				OP_Q2:    q2_q    <= mul_p;
				OP_P22DT: p22dt_q <= mul_p;
				OP_P21DT: t1_q    <= mul_p;
				OP_APRED: t2_q    <= mul_p;
				OP_VDT:   vdt_q   <= mul_p;
				default: ;
			endcase
		end

		if (state_q == ST_CALC) begin
			a_q     <= a_n;
			b_q     <= b_n;
			c_q     <= c_n;
			d_q     <= d_n;
			xp_q    <= xp_n;
			s_q     <= s_n;
			y_q     <= 33'(meas_q) - 33'(xp_n);
			fault_q <= s_n[48] || s_n == '0;
		end

		if (state_q == ST_DIV_WAIT && div_done) begin
			if (div_sel_q)
				k2_q <= div_q;
			else
				k1_q <= div_q;
		end

		if (state_q == ST_OUT && out_free) begin
			out_pos_q   <= pos_q;
			out_vel_q   <= vel_q;
			out_var_q   <= cov_q[0];
			out_fault_q <= fault_q;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.est_position      = out_pos_q;
	assign result.est_velocity      = out_vel_q;
	assign result.position_variance = out_var_q;
	assign result.fault             = out_fault_q;
endmodule
`default_nettype wire

### src/kfpv_checker.sv
// kfpv_checker: port-level checks on the Kalman filter top level.
// Bound to kalman_filter_position_velocity_unit; no package needed.
`default_nettype none
module kfpv_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);
	// A waiting result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// One transaction at a time: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// No result appears in the cycle straight after acceptance
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");
endmodule

bind kalman_filter_position_velocity_unit kfpv_checker u_kfpv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (meas.valid),
	.in_ready  (meas.ready),
	.out_valid (result.valid),
	.out_ready (result.ready)
);
`default_nettype wire
